// ----- sv/aarm_pkg.sv -----
`default_nettype none
package aarm_pkg;

  localparam int IN_FRAC_BITS  = 27;
  localparam int OUT_FRAC_BITS = 30;

  localparam int ISQRT_STEPS  = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;

  // The angle in Q.30 is the length shifted up by this many bits.
  localparam int ANG_SHIFT = 30 - IN_FRAC_BITS;
  localparam int ANG_W     = 32 + ANG_SHIFT;
  // Conditional subtractions of 2pi times a power of two.
  localparam int RED_STEPS = ANG_SHIFT;
  // Input register, squares, sum, root, prep, reduction, fold, CORDIC, three output stages.
  localparam int LAT = 3 + ISQRT_STEPS + 1 + RED_STEPS + 1 + CORDIC_STEPS + 3;

  localparam int OUT_SH = 30 - OUT_FRAC_BITS;
  localparam logic [35:0] OUT_HALF = (OUT_SH > 0) ? (36'd1 << (OUT_SH - 1)) : 36'd0;

  localparam logic [31:0] SMALL_LEN_MAX = 32'((64'd1 << IN_FRAC_BITS) / 100000);

  localparam logic [33:0] GAIN_Q30    = 34'd652032874;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
  localparam logic [31:0] ONE_OUT = 32'd1 << OUT_FRAC_BITS;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic               is_identity;
  } out_word_t;

  typedef struct packed {
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [2:0][30:0] q;
    logic [2:0]       lsb;
    logic [2:0]       neg;
    logic [31:0]      len;
  } div_t;

  typedef struct packed {
    logic [33:0] x;
    logic [33:0] y;
    logic [33:0] z;
    logic        flip;
  } cordic_t;

  // Product of two Q.30 values, rounded half up back to Q.30.
  function automatic logic signed [33:0] rnd_q30(input logic signed [69:0] p);
    logic signed [69:0] r;
    r = p + 70'sd536870912;
    return r[63:30];
  endfunction

  function automatic logic [31:0] out_fix(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + signed'(OUT_HALF)) >>> OUT_SH;
    if (r > 36'sd2147483647) begin
      return 32'h7fffffff;
    end else if (r < -36'sd2147483648) begin
      return 32'h80000000;
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/aarm_isqrt_cell.sv -----
`default_nettype none
module aarm_isqrt_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [63:0]       bit_i,
  input  aarm_pkg::sqrt_t   d_i,
  output aarm_pkg::sqrt_t   q_o
);

  aarm_pkg::sqrt_t cell_d, cell_q;
  logic [63:0]     trial;

  always_comb begin
    cell_d = d_i;
    trial  = d_i.res + bit_i;
    if (d_i.rem >= trial) begin
      cell_d.rem = d_i.rem - trial;
      cell_d.res = (d_i.res >> 1) + bit_i;
    end else begin
      cell_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

// ----- sv/aarm_div_cell.sv -----
`default_nettype none
module aarm_div_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  aarm_pkg::div_t  d_i,
  output aarm_pkg::div_t  q_o
);

  aarm_pkg::div_t cell_d, cell_q;
  logic [32:0]    trial [3];

  // One quotient bit per lane; the pending low bit of the magnitude enters first.
  always_comb begin
    cell_d     = d_i;
    cell_d.lsb = '0;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {d_i.r[l], d_i.lsb[l]};
      if (trial[l] >= {1'b0, d_i.len}) begin
        cell_d.r[l] = 32'(trial[l] - {1'b0, d_i.len});
        cell_d.q[l] = {d_i.q[l][29:0], 1'b1};
      end else begin
        cell_d.r[l] = trial[l][31:0];
        cell_d.q[l] = {d_i.q[l][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

// ----- sv/aarm_cordic_cell.sv -----
`default_nettype none
module aarm_cordic_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [4:0]        sh_i,
  input  logic [29:0]       atan_i,
  input  aarm_pkg::cordic_t d_i,
  output aarm_pkg::cordic_t q_o
);

  aarm_pkg::cordic_t  cell_d, cell_q;
  logic signed [33:0] x, y, z, dx, dy, at;

  always_comb begin
    x  = signed'(d_i.x);
    y  = signed'(d_i.y);
    z  = signed'(d_i.z);
    at = signed'({4'd0, atan_i});
    dx = y >>> sh_i;
    dy = x >>> sh_i;
    cell_d = d_i;
    if (!z[33]) begin
      cell_d.x = x - dx;
      cell_d.y = y + dy;
      cell_d.z = z - at;
    end else begin
      cell_d.x = x + dx;
      cell_d.y = y - dy;
      cell_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

// ----- sv/axis_angle_to_rotation_matrix.sv -----
`default_nettype none
// Rotation vector (Q4.27) to Rodrigues rotation matrix (Q1.30). The block is a
// fully pipelined chain and takes one word per cycle. Its depth is set by the 32
// square-root cells, followed in parallel by the 31 divider cells for the unit axis
// and by the angle reduction, with a stage for each bit that the angle is shifted up
// from the input format, plus 30 CORDIC cells. A stall on the output holds the whole
// pipeline, including the input side.
// Angles at or below 1e-5 rad give the identity with is_identity set.
module axis_angle_to_rotation_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aarm_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aarm_pkg::out_word_t out_word_o
);

  localparam int RED = aarm_pkg::RED_STEPS;
  localparam int LAT = aarm_pkg::LAT;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Input register, squares and sum of squares.
  aarm_pkg::in_word_t in_q;
  logic [63:0]        sq_q [3];
  logic [2:0][31:0]   mag_q;
  logic [2:0]         neg_q;
  aarm_pkg::sqrt_t    sq_chain [0:aarm_pkg::ISQRT_STEPS];

  logic signed [31:0] comp [3];
  logic signed [63:0] prod [3];

  always_comb begin
    comp[0] = in_q.rot_x;
    comp[1] = in_q.rot_y;
    comp[2] = in_q.rot_z;
    for (int l = 0; l < 3; l++) begin
      prod[l] = 64'(comp[l]) * 64'(comp[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_word_i;
      for (int l = 0; l < 3; l++) begin
        sq_q[l]  <= prod[l];
        neg_q[l] <= comp[l][31];
        mag_q[l] <= comp[l][31] ? (~comp[l] + 32'd1) : comp[l];
      end
      sq_chain[0].rem <= sq_q[0] + sq_q[1] + sq_q[2];
      sq_chain[0].res <= '0;
      sq_chain[0].mag <= mag_q;
      sq_chain[0].neg <= neg_q;
    end
  end

  for (genvar k = 0; k < aarm_pkg::ISQRT_STEPS; k++) begin : g_sqrt
    aarm_isqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .bit_i (64'h1 << (62 - 2 * k)),
      .d_i   (sq_chain[k]),
      .q_o   (sq_chain[k+1])
    );
  end

  // Prep: small-angle test, divider start and angle in Q.30.
  aarm_pkg::sqrt_t   root;
  logic [31:0]       len;
  aarm_pkg::div_t    dv [0:aarm_pkg::DIV_STEPS];
  logic [aarm_pkg::ANG_W-1:0] red_q [0:RED];
  logic              sm_q [0:RED+aarm_pkg::CORDIC_STEPS+1];

  assign root = sq_chain[aarm_pkg::ISQRT_STEPS];
  assign len  = root.res[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q[0]  <= (len <= aarm_pkg::SMALL_LEN_MAX);
      red_q[0] <= aarm_pkg::ANG_W'({len, {aarm_pkg::ANG_SHIFT{1'b0}}});
      dv[0].len <= len;
      dv[0].neg <= root.neg;
      for (int l = 0; l < 3; l++) begin
        dv[0].r[l]   <= {1'b0, root.mag[l][31:1]};
        dv[0].lsb[l] <= root.mag[l][0];
        dv[0].q[l]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < RED + aarm_pkg::CORDIC_STEPS + 1; k++) begin : g_sm
    always_ff @(posedge clk_i) begin
      if (en) begin
        sm_q[k+1] <= sm_q[k];
      end
    end
  end

  for (genvar k = 0; k < aarm_pkg::DIV_STEPS; k++) begin : g_div
    aarm_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv[k]),
      .q_o   (dv[k+1])
    );
  end

  aarm_pkg::div_t nd [0:RED];
  assign nd[0] = dv[aarm_pkg::DIV_STEPS];

  for (genvar k = 0; k < RED; k++) begin : g_nd
    always_ff @(posedge clk_i) begin
      if (en) begin
        nd[k+1] <= nd[k];
      end
    end
  end

  // Reduce the angle modulo 2pi by subtracting 2pi times a falling power of two.
  for (genvar j = 0; j < RED; j++) begin : g_red
    localparam logic [63:0] SUB = aarm_pkg::TWO_PI_Q30 << (RED - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (64'(red_q[j]) >= SUB) begin
          red_q[j+1] <= aarm_pkg::ANG_W'(64'(red_q[j]) - SUB);
        end else begin
          red_q[j+1] <= red_q[j];
        end
      end
    end
  end

  // Fold [0, 2pi) into [-pi/2, pi/2], flipping cos and sin when pi is moved in.
  aarm_pkg::cordic_t  cd [0:aarm_pkg::CORDIC_STEPS];
  logic [63:0]        a64;
  logic signed [63:0] zf;
  logic               flip;

  always_comb begin
    a64  = 64'(red_q[RED]);
    flip = 1'b0;
    if (a64 > aarm_pkg::HALF_PI_Q30 &&
        a64 < aarm_pkg::TWO_PI_Q30 - aarm_pkg::HALF_PI_Q30) begin
      zf   = signed'(a64 - aarm_pkg::PI_Q30);
      flip = 1'b1;
    end else if (a64 > aarm_pkg::PI_Q30) begin
      zf = signed'(a64 - aarm_pkg::TWO_PI_Q30);
    end else begin
      zf = signed'(a64);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd[0].x    <= aarm_pkg::GAIN_Q30;
      cd[0].y    <= '0;
      cd[0].z    <= zf[33:0];
      cd[0].flip <= flip;
    end
  end

  for (genvar k = 0; k < aarm_pkg::CORDIC_STEPS; k++) begin : g_cordic
    aarm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .sh_i   (5'(k)),
      .atan_i (aarm_pkg::ATAN_Q30[k]),
      .d_i    (cd[k]),
      .q_o    (cd[k+1])
    );
  end

  // Stage one of the matrix: cos, sin, t = 1 - cos, signed axis and t times axis.
  aarm_pkg::cordic_t  cf;
  aarm_pkg::div_t     nf;
  logic signed [34:0] c35, s35, t35;
  logic signed [31:0] n_v [3];
  logic signed [33:0] tn_v [3];

  logic signed [31:0] m1_n_q [3];
  logic signed [33:0] m1_tn_q [3];
  logic signed [34:0] m1_c_q, m1_s_q;
  logic               m1_sm_q;

  assign cf = cd[aarm_pkg::CORDIC_STEPS];
  assign nf = nd[RED];

  always_comb begin
    c35 = cf.flip ? -35'(signed'(cf.x)) : 35'(signed'(cf.x));
    s35 = cf.flip ? -35'(signed'(cf.y)) : 35'(signed'(cf.y));
    t35 = aarm_pkg::ONE_Q30 - c35;
    for (int l = 0; l < 3; l++) begin
      n_v[l]  = nf.neg[l] ? -signed'({1'b0, nf.q[l]}) : signed'({1'b0, nf.q[l]});
      tn_v[l] = aarm_pkg::rnd_q30(70'(n_v[l]) * 70'(t35));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        m1_n_q[l]  <= n_v[l];
        m1_tn_q[l] <= tn_v[l];
      end
      m1_c_q  <= c35;
      m1_s_q  <= s35;
      m1_sm_q <= sm_q[RED + aarm_pkg::CORDIC_STEPS + 1];
    end
  end

  // Stage two: the twelve distinct products.
  logic signed [33:0] pr_v [12];
  logic signed [33:0] pr_q [12];
  logic signed [34:0] m2_c_q;
  logic               m2_sm_q;

  always_comb begin
    pr_v[0]  = aarm_pkg::rnd_q30(70'(m1_n_q[0]) * 70'(m1_tn_q[0]));
    pr_v[1]  = aarm_pkg::rnd_q30(70'(m1_n_q[1]) * 70'(m1_tn_q[0]));
    pr_v[2]  = aarm_pkg::rnd_q30(70'(m1_n_q[2]) * 70'(m1_s_q));
    pr_v[3]  = aarm_pkg::rnd_q30(70'(m1_tn_q[0]) * 70'(m1_n_q[2]));
    pr_v[4]  = aarm_pkg::rnd_q30(70'(m1_n_q[1]) * 70'(m1_s_q));
    pr_v[5]  = aarm_pkg::rnd_q30(70'(m1_tn_q[1]) * 70'(m1_n_q[0]));
    pr_v[6]  = aarm_pkg::rnd_q30(70'(m1_n_q[1]) * 70'(m1_tn_q[1]));
    pr_v[7]  = aarm_pkg::rnd_q30(70'(m1_tn_q[1]) * 70'(m1_n_q[2]));
    pr_v[8]  = aarm_pkg::rnd_q30(70'(m1_n_q[0]) * 70'(m1_s_q));
    pr_v[9]  = aarm_pkg::rnd_q30(70'(m1_n_q[0]) * 70'(m1_tn_q[2]));
    pr_v[10] = aarm_pkg::rnd_q30(70'(m1_n_q[1]) * 70'(m1_tn_q[2]));
    pr_v[11] = aarm_pkg::rnd_q30(70'(m1_n_q[2]) * 70'(m1_tn_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        pr_q[k] <= pr_v[k];
      end
      m2_c_q  <= m1_c_q;
      m2_sm_q <= m1_sm_q;
    end
  end

  // Stage three: entry sums, output rounding, saturation and the identity case.
  logic signed [35:0]  cx;
  logic signed [35:0]  p36 [12];
  aarm_pkg::out_word_t out_d, out_q;

  always_comb begin
    cx = 36'(m2_c_q);
    for (int k = 0; k < 12; k++) begin
      p36[k] = 36'(pr_q[k]);
    end
    out_d.m00 = aarm_pkg::out_fix(p36[0] + cx);
    out_d.m01 = aarm_pkg::out_fix(p36[1] + p36[2]);
    out_d.m02 = aarm_pkg::out_fix(p36[3] - p36[4]);
    out_d.m10 = aarm_pkg::out_fix(p36[5] - p36[2]);
    out_d.m11 = aarm_pkg::out_fix(p36[6] + cx);
    out_d.m12 = aarm_pkg::out_fix(p36[7] + p36[8]);
    out_d.m20 = aarm_pkg::out_fix(p36[9] + p36[4]);
    out_d.m21 = aarm_pkg::out_fix(p36[10] - p36[8]);
    out_d.m22 = aarm_pkg::out_fix(p36[11] + cx);
    out_d.is_identity = m2_sm_q;
    if (m2_sm_q) begin
      out_d.m00 = aarm_pkg::ONE_OUT;
      out_d.m01 = '0;
      out_d.m02 = '0;
      out_d.m10 = '0;
      out_d.m11 = aarm_pkg::ONE_OUT;
      out_d.m12 = '0;
      out_d.m20 = '0;
      out_d.m21 = '0;
      out_d.m22 = aarm_pkg::ONE_OUT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

`ifndef SYNTHESIS
  a_stall_only_on_held_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  a_identity_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_identity |->
      out_word_o.m00 == aarm_pkg::ONE_OUT && out_word_o.m11 == aarm_pkg::ONE_OUT &&
      out_word_o.m22 == aarm_pkg::ONE_OUT)
    else $error("identity word without unit diagonal");

  a_identity_offdiag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_identity |->
      out_word_o.m01 == 0 && out_word_o.m02 == 0 && out_word_o.m10 == 0 &&
      out_word_o.m12 == 0 && out_word_o.m20 == 0 && out_word_o.m21 == 0)
    else $error("identity word with nonzero off-diagonal entry");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved while stalled");
`endif

endmodule
`default_nettype wire
